// ===== design/kwm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwm_pkg: shared types and constants of the k-way merge
// Payload structs of both channels, the queue entry passed from the front
// end to the merge engine, operation codes and fixed sizes.
// ----------------------------------------------------------------------------
package kwm_pkg;

   localparam int VALUE_W     = 32;
   localparam int RUN_W       = 4;
   localparam int CSR_W       = 5;

   // Power of two, so the queue pointers wrap on their own.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_W-1:0] RUNS_RESET = 5'd16;

   localparam logic OP_ELEMENT = 1'b0;
   localparam logic OP_END     = 1'b1;

   typedef struct packed {
      logic                      operation;
      logic [RUN_W-1:0]          run_index;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_out;
      logic [RUN_W-1:0]          source_run;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic                      in_use;
      logic                      operation;
      logic [RUN_W-1:0]          run_index;
      logic signed [VALUE_W-1:0] value;
   } entry_type;

endpackage

// ===== design/k_way_merge.sv =====
// ----------------------------------------------------------------------------
// k_way_merge: merge of sorted runs into one ascending stream
// Front end, queue and merge engine of a k-way merge over signed values.
// ----------------------------------------------------------------------------
// Usage:
// The feeder sends one request per transfer on req_: an element for a run,
// or an end marker saying that run has no more elements. Once every run in
// use holds a head or is exhausted, the smallest head (lowest run on ties)
// leaves on rsp_ together with its source run, which the feeder refills
// next. The final value of a merge carries last, and all flags then clear.
// A merge whose runs are all exhausted with no heads clears silently.
// An accepted request enters the queue; the engine pops it and registers any
// response. One request is taken per cycle unless req_stall is high; the limit
// is the merge engine, which updates one head and evaluates the compare tree
// over all heads each cycle. While rsp_stall holds a pending response, the
// engine waits and the two-entry queue fills before req_stall rises.
// csr_wr_en writes runs_in_use (0 acts as 1, values above MAX_RUNS act as
// MAX_RUNS); write it only while the block is idle.
// Synchronous reset empties the queue and flags and sets runs_in_use to 16.
// ----------------------------------------------------------------------------
module k_way_merge #(
   parameter int MAX_RUNS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [kwm_pkg::CSR_W-1:0]    csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  kwm_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output kwm_pkg::rsp_type             rsp_data
);

   localparam int NW = $clog2(MAX_RUNS + 1);

   logic               queue_full;
   logic               push;
   logic               pop;
   logic               q_not_empty;
   kwm_pkg::entry_type push_entry;
   kwm_pkg::entry_type q_entry;
   logic [NW-1:0]      active_runs;

   assign req_stall = queue_full;

   kwm_front #(.MAX_RUNS(MAX_RUNS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry),
      .active_runs (active_runs)
   );

   kwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (q_not_empty),
      .head_entry (q_entry)
   );

   kwm_engine #(.MAX_RUNS(MAX_RUNS)) u_engine (
      .clock       (clock),
      .reset       (reset),
      .active_runs (active_runs),
      .q_not_empty (q_not_empty),
      .q_entry     (q_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== design/kwm_front.sv =====
// ----------------------------------------------------------------------------
// kwm_front: request intake and classification
// Holds the runs_in_use register, clamps it to the supported range and tags
// each accepted request with whether its run takes part in the merge.
// ----------------------------------------------------------------------------
module kwm_front #(
   parameter int MAX_RUNS = 16,
   localparam int NW = $clog2(MAX_RUNS + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [kwm_pkg::CSR_W-1:0]        csr_wr_data,
   input  logic                             req_valid,
   input  kwm_pkg::req_type                 req_data,
   input  logic                             queue_full,
   output logic                             push,
   output kwm_pkg::entry_type               push_entry,
   output logic [NW-1:0]                    active_runs
);

   logic [kwm_pkg::CSR_W-1:0] runs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         runs_ff <= kwm_pkg::RUNS_RESET;
      end else if (csr_wr_en) begin
         runs_ff <= csr_wr_data;
      end
   end

   // Zero acts as one run; anything above the instance size acts as the size.
   always_comb begin
      if (runs_ff == '0) begin
         active_runs = NW'(1);
      end else if (int'(runs_ff) > MAX_RUNS) begin
         active_runs = NW'(MAX_RUNS);
      end else begin
         active_runs = NW'(runs_ff);
      end
   end

   assign push = req_valid && !queue_full;

   always_comb begin
      push_entry.in_use    = int'(req_data.run_index) < int'(active_runs);
      push_entry.operation = req_data.operation;
      push_entry.run_index = req_data.run_index;
      push_entry.value     = req_data.value;
   end

endmodule

// ===== design/kwm_queue.sv =====
// ----------------------------------------------------------------------------
// kwm_queue: short queue between front end and merge engine
// A small circular buffer that lets intake continue while the merge engine
// waits on the response side.
// ----------------------------------------------------------------------------
module kwm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  kwm_pkg::entry_type   push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output kwm_pkg::entry_type   head_entry
);

   localparam int PW = $clog2(kwm_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(kwm_pkg::QUEUE_DEPTH + 1);

   kwm_pkg::entry_type mem_ff [kwm_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   assign full       = count_ff == CW'(kwm_pkg::QUEUE_DEPTH);
   assign not_empty  = count_ff != '0;
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !pop |-> !push)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");
`endif

endmodule

// ===== design/kwm_engine.sv =====
// ----------------------------------------------------------------------------
// kwm_engine: merge engine
// Holds one head per run with valid and exhausted flags, applies one queued
// item per cycle unless a stalled response holds it, picks the smallest head
// through a compare tree and loads the response register.
// ----------------------------------------------------------------------------
module kwm_engine #(
   parameter int MAX_RUNS = 16,
   localparam int NW = $clog2(MAX_RUNS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [NW-1:0]        active_runs,
   input  logic                 q_not_empty,
   input  kwm_pkg::entry_type   q_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output kwm_pkg::rsp_type     rsp_data
);

   localparam int IW = $clog2(MAX_RUNS);
   localparam int P  = 1 << IW;
   localparam int VW = kwm_pkg::VALUE_W;

   logic signed [VW-1:0] head_ff [MAX_RUNS];
   logic [MAX_RUNS-1:0]  valid_ff;
   logic [MAX_RUNS-1:0]  exh_ff;
   logic                 rsp_valid_ff;
   kwm_pkg::rsp_type     rsp_data_ff;

   logic [MAX_RUNS-1:0]  wr_head;
   logic [MAX_RUNS-1:0]  mark_end;
   logic [MAX_RUNS-1:0]  in_use_mask;
   logic [MAX_RUNS-1:0]  nv;
   logic [MAX_RUNS-1:0]  ne;
   logic [MAX_RUNS-1:0]  nv_taken;
   logic [MAX_RUNS-1:0]  best_sel;
   logic signed [VW-1:0] leaf_val [MAX_RUNS];

   logic                 tv [2*P-1];
   logic signed [VW-1:0] tval [2*P-1];
   logic [IW-1:0]        tidx [2*P-1];
   logic                 take_left;

   logic [IW-1:0]        best;
   logic                 ready;
   logic                 any_valid;
   logic                 remaining;
   logic                 all_done;
   logic                 emit;
   logic                 is_last;
   logic                 clear;
   logic [MAX_RUNS-1:0]  valid_in;
   logic [MAX_RUNS-1:0]  exh_in;

   assign pop = q_not_empty && (!rsp_valid_ff || !rsp_stall);

   // Apply the queued item to the flags and heads as seen by this cycle.
   always_comb begin
      for (int i = 0; i < MAX_RUNS; i++) begin
         in_use_mask[i] = i < int'(active_runs);
         wr_head[i]  = pop && q_entry.in_use && q_entry.operation == kwm_pkg::OP_ELEMENT
                       && !exh_ff[i] && int'(q_entry.run_index) == i;
         mark_end[i] = pop && q_entry.in_use && q_entry.operation == kwm_pkg::OP_END
                       && int'(q_entry.run_index) == i;
         leaf_val[i] = wr_head[i] ? q_entry.value : head_ff[i];
      end
      nv = valid_ff | wr_head;
      ne = exh_ff | mark_end;
   end

   // Heap-ordered argmin tree; the left child always covers lower run
   // indices, so preferring it on equal values resolves ties.
   always_comb begin
      take_left = 1'b0;
      for (int i = 0; i < P; i++) begin
         if (i < MAX_RUNS) begin
            tv[P-1+i]   = nv[i] && in_use_mask[i];
            tval[P-1+i] = leaf_val[i];
         end else begin
            tv[P-1+i]   = 1'b0;
            tval[P-1+i] = '0;
         end
         tidx[P-1+i] = IW'(i);
      end
      for (int k = P - 2; k >= 0; k--) begin
         take_left = tv[2*k+1] && (!tv[2*k+2] || tval[2*k+1] <= tval[2*k+2]);
         tv[k]     = tv[2*k+1] || tv[2*k+2];
         tval[k]   = take_left ? tval[2*k+1] : tval[2*k+2];
         tidx[k]   = take_left ? tidx[2*k+1] : tidx[2*k+2];
      end
   end

   assign best      = tidx[0];
   assign any_valid = tv[0];

   always_comb begin
      for (int i = 0; i < MAX_RUNS; i++) begin
         best_sel[i] = IW'(i) == best;
      end
      nv_taken  = nv & ~best_sel;
      ready     = &(nv | ne | ~in_use_mask);
      remaining = |(nv_taken & in_use_mask);
      all_done  = &(ne | ~in_use_mask);
      emit      = pop && ready && any_valid;
      is_last   = emit && !remaining && all_done;
      clear     = pop && ready && (!any_valid || is_last);

      valid_in = valid_ff;
      exh_in   = exh_ff;
      if (clear) begin
         valid_in = '0;
         exh_in   = '0;
      end else if (pop) begin
         valid_in = emit ? nv_taken : nv;
         exh_in   = ne;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         exh_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         exh_ff   <= exh_in;
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RUNS; i++) begin
         if (wr_head[i]) begin
            head_ff[i] <= q_entry.value;
         end
      end
      if (emit) begin
         rsp_data_ff.value_out  <= tval[0];
         rsp_data_ff.source_run <= kwm_pkg::RUN_W'(best);
         rsp_data_ff.last       <= is_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      is_last |=> valid_ff == '0 && exh_ff == '0)
      else $error("state not cleared after final transfer");
   a_taken_head_empty: assert property (@(posedge clock) disable iff (reset)
      emit |=> !valid_ff[$past(best)])
      else $error("emitted head still marked valid");
   a_exh_sticky: assert property (@(posedge clock) disable iff (reset)
      !clear |=> (exh_ff & $past(exh_ff)) == $past(exh_ff))
      else $error("exhausted flag dropped without a clear");
   a_emit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emitted value did not reach the response register");
`endif

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the k-way merge
// Feeds sorted runs the way a real feeder would, refilling the run that each
// merged value came from, mixed with stray requests. A merge model in this
// file predicts all but typed-in responses; the scoreboard checks them in order
// across several runs_in_use settings and idle, stall and backpressure phases.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 11;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 80;
   localparam int NUM_RUNS       = 16;

   typedef enum logic [1:0] {
      STEP_CSR,
      STEP_CHECKED,
      STEP_TYPED
   } step_kind_type;

   typedef struct packed {
      step_kind_type             kind;
      logic [kwm_pkg::CSR_W-1:0] csr;
      kwm_pkg::req_type          req;
      logic                      typed_has;
      kwm_pkg::rsp_type          typed_rsp;
   } dir_step_type;

   // Expected responses are typed in only for the extremes, the last flag and
   // the zero setting; every other step is checked against the merge model.
   localparam dir_step_type DIRECTED [29] = '{
      '{STEP_CSR,     5'd2, '0, 1'b0, '0},
      '{STEP_TYPED,   5'd0, '{kwm_pkg::OP_ELEMENT, 4'd0, 32'sh7FFF_FFFF}, 1'b0, '0},
      '{STEP_TYPED,   5'd0, '{kwm_pkg::OP_ELEMENT, 4'd1, 32'sh8000_0000}, 1'b1,
        '{32'sh8000_0000, 4'd1, 1'b0}},
      '{STEP_TYPED,   5'd0, '{kwm_pkg::OP_END, 4'd1, -32'sd1}, 1'b1,
        '{32'sh7FFF_FFFF, 4'd0, 1'b0}},
      '{STEP_TYPED,   5'd0, '{kwm_pkg::OP_END, 4'd0, 32'sd0}, 1'b0, '0},
      '{STEP_CHECKED, 5'd0, '{kwm_pkg::OP_ELEMENT, 4'd0, 32'sd5}, 1'b0, '0},
      '{STEP_CHECKED, 5'd0, '{kwm_pkg::OP_ELEMENT, 4'd1, 32'sd5}, 1'b0, '0},
      '{STEP_CHECKED, 5'd0, '{kwm_pkg::OP_ELEMENT, 4'd1, 32'sd9}, 1'b0, '0},
      '{STEP_CHECKED, 5'd0, '{kwm_pkg::OP_ELEMENT, 4'd0, 32'sd6}, 1'b0, '0},
      '{STEP_CHECKED, 5'd0, '{kwm_pkg::OP_END, 4'd0, 32'sd0}, 1'b0, '0},
      '{STEP_CHECKED, 5'd0, '{kwm_pkg::OP_ELEMENT, 4'd1, 32'sd12}, 1'b0, '0},
      '{STEP_CHECKED, 5'd0, '{kwm_pkg::OP_END, 4'd1, 32'sd0}, 1'b0, '0},
      '{STEP_CHECKED, 5'd0, '{kwm_pkg::OP_ELEMENT, 4'd0, 32'sd7}, 1'b0, '0},
      '{STEP_CHECKED, 5'd0, '{kwm_pkg::OP_END, 4'd0, 32'sd0}, 1'b0, '0},
      '{STEP_TYPED,   5'd0, '{kwm_pkg::OP_END, 4'd1, 32'sd0}, 1'b1,
        '{32'sd7, 4'd0, 1'b1}},
      '{STEP_CHECKED, 5'd0, '{kwm_pkg::OP_END, 4'd0, 32'sd0}, 1'b0, '0},
      '{STEP_CHECKED, 5'd0, '{kwm_pkg::OP_ELEMENT, 4'd0, 32'sd3}, 1'b0, '0},
      '{STEP_CHECKED, 5'd0, '{kwm_pkg::OP_END, 4'd1, 32'sd0}, 1'b0, '0},
      '{STEP_CSR,     5'd0, '0, 1'b0, '0},
      '{STEP_TYPED,   5'd0, '{kwm_pkg::OP_ELEMENT, 4'd0, -32'sd3}, 1'b1,
        '{-32'sd3, 4'd0, 1'b0}},
      '{STEP_CHECKED, 5'd0, '{kwm_pkg::OP_ELEMENT, 4'd1, 32'sd2}, 1'b0, '0},
      '{STEP_CHECKED, 5'd0, '{kwm_pkg::OP_END, 4'd0, 32'sd0}, 1'b0, '0},
      '{STEP_CSR,     5'd3, '0, 1'b0, '0},
      '{STEP_CHECKED, 5'd0, '{kwm_pkg::OP_ELEMENT, 4'd2, 32'sd10}, 1'b0, '0},
      '{STEP_CHECKED, 5'd0, '{kwm_pkg::OP_ELEMENT, 4'd0, 32'sd20}, 1'b0, '0},
      '{STEP_CSR,     5'd2, '0, 1'b0, '0},
      '{STEP_CHECKED, 5'd0, '{kwm_pkg::OP_ELEMENT, 4'd1, 32'sd30}, 1'b0, '0},
      '{STEP_CHECKED, 5'd0, '{kwm_pkg::OP_END, 4'd0, 32'sd0}, 1'b0, '0},
      '{STEP_CHECKED, 5'd0, '{kwm_pkg::OP_END, 4'd1, 32'sd0}, 1'b0, '0}
   };

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      csr_wr_en   = 1'b0;
   logic [kwm_pkg::CSR_W-1:0] csr_wr_data = '0;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   kwm_pkg::req_type          req_data    = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   kwm_pkg::rsp_type          rsp_data;

   // Merge model state.
   logic signed [kwm_pkg::VALUE_W-1:0] head_val [NUM_RUNS];
   bit                                 head_full [NUM_RUNS];
   bit                                 run_closed [NUM_RUNS];
   logic [kwm_pkg::CSR_W-1:0]          runs_reg = kwm_pkg::RUNS_RESET;

   kwm_pkg::rsp_type pending_merged [$];
   int      mismatches    = 0;
   int      results_seen  = 0;
   int      items_sent    = 0;
   int      send_idle_pct = 0;
   int      stall_pct     = 0;
   int      hold_seq      = 0;
   int      hold_seen     = 0;
   int      hold_left     = 0;

   k_way_merge i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic int active_runs();
      if (runs_reg == 0) return 1;
      if (runs_reg > NUM_RUNS) return NUM_RUNS;
      return int'(runs_reg);
   endfunction

   function automatic void clear_heads();
      int i;
      for (i = 0; i < NUM_RUNS; i++) begin
         head_val[i]   = '0;
         head_full[i]  = 1'b0;
         run_closed[i] = 1'b0;
      end
   endfunction

   // Applies one request to the model; returns 1 when it yields a merged value.
   function automatic bit merge_predict(input kwm_pkg::req_type item,
                                        output kwm_pkg::rsp_type res);
      int n;
      int best;
      int i;
      bit ready;
      bit any_full;
      bit remaining;
      bit all_closed;
      n = active_runs();
      res = '0;
      if (int'(item.run_index) < n) begin
         if (item.operation == kwm_pkg::OP_ELEMENT) begin
            if (!run_closed[item.run_index]) begin
               head_val[item.run_index]  = item.value;
               head_full[item.run_index] = 1'b1;
            end
         end else begin
            run_closed[item.run_index] = 1'b1;
         end
      end
      ready = 1'b1;
      any_full = 1'b0;
      best = 0;
      for (i = 0; i < n; i++) begin
         if (!head_full[i] && !run_closed[i]) ready = 1'b0;
         if (head_full[i]) begin
            if (!any_full || head_val[i] < head_val[best]) best = i;
            any_full = 1'b1;
         end
      end
      if (!ready) return 1'b0;
      // Every run in use is exhausted and nothing is held: silent clear.
      if (!any_full) begin
         clear_heads();
         return 1'b0;
      end
      head_full[best] = 1'b0;
      remaining = 1'b0;
      all_closed = 1'b1;
      for (i = 0; i < n; i++) begin
         if (head_full[i]) remaining = 1'b1;
         if (!run_closed[i]) all_closed = 1'b0;
      end
      res.value_out  = head_val[best];
      res.source_run = 4'(best);
      res.last       = !remaining && all_closed;
      if (res.last) clear_heads();
      return 1'b1;
   endfunction

   // Offers one request and returns once it has been transferred.
   task automatic send_item(input kwm_pkg::req_type item, output bit has,
                            output kwm_pkg::rsp_type res);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      has = merge_predict(item, res);
   endtask

   // Stops offering and waits until every expected value has arrived.
   task automatic quiesce(input int extra);
      req_valid <= 1'b0;
      while (pending_merged.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_runs(input logic [kwm_pkg::CSR_W-1:0] setting);
      // Requests that yield nothing may still be in flight after the last
      // response, so give the pipeline time to drain.
      quiesce(SETTLE_CYCLES);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= setting;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      runs_reg = setting;
   endtask

   // One merge: ascending runs, first a request for every run in use, then the run
   // that supplied each merged value is refilled, with stray requests mixed in.
   task automatic run_merge(input int max_len, input int noise_pct);
      int               pool [$];
      int               vals [$];
      int               first [NUM_RUNS];
      int               count [NUM_RUNS];
      int               taken [NUM_RUNS];
      int               refill [$];
      int               n;
      int               r;
      int               j;
      bit               narrow;
      bit               has;
      kwm_pkg::req_type item;
      kwm_pkg::rsp_type res;
      n = active_runs();
      narrow = 1'($urandom_range(0, 1));
      for (r = 0; r < NUM_RUNS; r++) begin
         vals.delete();
         count[r] = $urandom_range(0, max_len);
         taken[r] = 0;
         for (j = 0; j < count[r]; j++) begin
            if (narrow) vals.push_back(int'($urandom_range(0, 6)) - 3);
            else vals.push_back(int'($urandom));
         end
         vals.sort();
         first[r] = pool.size();
         for (j = 0; j < vals.size(); j++) pool.push_back(vals[j]);
      end
      for (r = 0; r < n; r++) refill.insert($urandom_range(0, refill.size()), r);
      while (refill.size() != 0) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            item.operation = 1'($urandom_range(0, 1));
            item.run_index = 4'($urandom_range(0, NUM_RUNS - 1));
            item.value     = $urandom;
         end else begin
            r = refill.pop_front();
            item.run_index = 4'(r);
            if (taken[r] < count[r]) begin
               item.operation = kwm_pkg::OP_ELEMENT;
               item.value     = pool[first[r] + taken[r]];
               taken[r]++;
            end else begin
               item.operation = kwm_pkg::OP_END;
               item.value     = $urandom;
            end
         end
         send_item(item, has, res);
         if (has) begin
            pending_merged.push_back(res);
            if (!res.last) refill.push_back(int'(res.source_run));
         end
      end
   endtask

   // Response checking and receiver stall generation.
   always @(posedge clock) begin
      kwm_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_merged.size() == 0) begin
            mismatches++;
            $display("%0t: expected no value, got %0d from run %0d last %0b", $time,
                     rsp_data.value_out, rsp_data.source_run, rsp_data.last);
         end else begin
            want = pending_merged.pop_front();
            if (rsp_data.value_out !== want.value_out ||
                rsp_data.source_run !== want.source_run ||
                rsp_data.last !== want.last) begin
               mismatches++;
               $display("%0t: expected %0d run %0d last %0b, got %0d run %0d last %0b",
                        $time, want.value_out, want.source_run, want.last,
                        rsp_data.value_out, rsp_data.source_run, rsp_data.last);
            end
         end
      end
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   initial begin
      bit               has;
      kwm_pkg::rsp_type res;
      clear_heads();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[k]) begin
         if (DIRECTED[k].kind == STEP_CSR) begin
            write_runs(DIRECTED[k].csr);
         end else begin
            send_item(DIRECTED[k].req, has, res);
            if (DIRECTED[k].kind == STEP_TYPED) begin
               has = DIRECTED[k].typed_has;
               res = DIRECTED[k].typed_rsp;
            end
            if (has) pending_merged.push_back(res);
         end
      end

      write_runs(5'd16);
      while (items_sent < 140) run_merge(3, 8);

      write_runs(5'd1);
      send_idle_pct = 69;
      while (items_sent < 190) run_merge(8, 10);

      write_runs(5'd31);
      send_idle_pct = 0;
      stall_pct     = 69;
      while (items_sent < 280) run_merge(3, 8);

      write_runs(5'd5);
      send_idle_pct = 19;
      stall_pct     = 19;
      while (items_sent < 370) run_merge(5, 10);

      write_runs(5'd0);
      send_idle_pct = 0;
      stall_pct     = 0;
      while (items_sent < 400) run_merge(6, 15);

      // Long receiver hold-off while requests keep coming, so the block fills
      // up and stalls its input; then the feeder pauses until all is drained.
      write_runs(5'd16);
      hold_seq++;
      run_merge(4, 5);
      quiesce(1);
      run_merge(3, 5);

      quiesce(SETTLE_CYCLES);
      $display("Sent %0d requests and checked %0d merged values across runs_in_use",
               items_sent, results_seen);
      $display("settings 0 to 31 with idle, stall and full backpressure phases.");
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
      $display("Timed out with %0d merged values outstanding.", pending_merged.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
design/kwm_pkg.sv
design/kwm_front.sv
design/kwm_queue.sv
design/kwm_engine.sv
design/k_way_merge.sv
test/tb_top.sv
